// ----- rtl/piecewise_linear_color_ramp_assert.svh -----
// Assertion macros used by the checker file (plcr_checker).
`ifndef PIECEWISE_LINEAR_COLOR_RAMP_ASSERT_SVH
`define PIECEWISE_LINEAR_COLOR_RAMP_ASSERT_SVH
// Assert an implication sampled on the rising clock, disabled in reset.
`define PLCR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert an implication whose consequent holds in the cycle after the antecedent.
`define PLCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/plcr_pkg.sv -----
// ----------------------------------------------------------------------------
// plcr_pkg
// Types and constants shared by the color ramp modules.
// ----------------------------------------------------------------------------
package plcr_pkg;
	localparam int MaxBp = 16;
	localparam int IdxW = $clog2(MaxBp);
	localparam int CntW = $clog2(MaxBp + 1);
	localparam int PosW = 17;
	localparam int ColW = 32;
	localparam logic [PosW-1:0] OnePos = 17'd65536;

	typedef enum logic [1:0] {
		FUNC_SET = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_SAMPLE = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_SAME = 3'd1,
		ST_RANGE = 3'd2,
		ST_FULL = 3'd3,
		ST_MISSING = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_DECIDE,
		S_SHUP_RD,
		S_SHUP_WR,
		S_SHDN_RD,
		S_SHDN_WR,
		S_SMP_RD,
		S_SMP_LD,
		S_DIV,
		S_DONE
	} state_t;

	// Divider control between sequencer and divide unit
	typedef struct packed {
		logic start;
		logic [8:0] num_mag;
		logic [16:0] frac;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [7:0] quo;
	} div_rsp_t;
endpackage

// ----- rtl/piecewise_linear_color_ramp.sv -----
// Set and remove search the table, then shift entries up to insert or down
// to remove; sample searches, reads the neighbouring entries and runs four
// divides, one per color channel.
// Throughput: one item at a time; the next input transfer can follow the
// cycle after the result transfer. Reset empties the table (count zero).
// ----------------------------------------------------------------------------
// piecewise_linear_color_ramp
// Breakpoint table with set, remove and interpolated sample.
// ----------------------------------------------------------------------------
module piecewise_linear_color_ramp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [16:0] position,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic [2:0]  status
);
	localparam int IW = plcr_pkg::IdxW;
	localparam int CW = plcr_pkg::CntW;

	plcr_pkg::state_t state_q, state_d;
	plcr_pkg::func_t func_q;
	logic [16:0] pos_q;
	logic [31:0] col_q;
	logic [CW-1:0] cnt_q, idx_q, j_q;
	logic [31:0] res_q;
	logic [2:0] st_q;
	logic [16:0] kp_q, kn_q;
	logic [31:0] cp_q, cn_q;
	logic [1:0] ch_q;
	logic ovalid_q;
	logic first_q;

	// RAM ports
	logic we;
	logic [IW-1:0] waddr, raddr;
	logic [16:0] kw, kr;
	logic [31:0] cw, cr;

	plcr_ram #(.Width(17), .Depth(plcr_pkg::MaxBp)) u_key (
		.clk(clk), .we(we), .waddr(waddr), .wdata(kw), .raddr(raddr), .rdata(kr));
	plcr_ram #(.Width(32), .Depth(plcr_pkg::MaxBp)) u_col (
		.clk(clk), .we(we), .waddr(waddr), .wdata(cw), .raddr(raddr), .rdata(cr));

	plcr_pkg::div_req_t dreq;
	plcr_pkg::div_rsp_t drsp;
	plcr_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic in_acc, out_acc;
	logic found;
	logic [7:0] ca, cb, chv;
	logic [8:0] dmag;
	logic neg;
	logic [4:0] sh;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != plcr_pkg::S_IDLE) || ovalid_q;
	assign found = (idx_q < cnt_q) && (kr == pos_q);

	// Channel select for the current blend step (red first)
	assign sh = 5'(24 - 8 * ch_q);
	assign ca = 8'(cp_q >> sh);
	assign cb = 8'(cn_q >> sh);
	assign neg = cb < ca;
	assign dmag = neg ? 9'(ca - cb) : 9'(cb - ca);
	assign chv = neg ? 8'(ca - drsp.quo) : 8'(ca + drsp.quo);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			plcr_pkg::S_IDLE: if (in_acc) state_d = plcr_pkg::S_DECIDE;
			plcr_pkg::S_SRCH_RD: state_d = plcr_pkg::S_SRCH_CHK;
			plcr_pkg::S_SRCH_CHK: begin
				if (idx_q < cnt_q && kr < pos_q) state_d = plcr_pkg::S_SRCH_RD;
				else if (func_q == plcr_pkg::FUNC_SAMPLE) state_d = plcr_pkg::S_SMP_RD;
				else if (func_q == plcr_pkg::FUNC_REMOVE)
					state_d = found ? plcr_pkg::S_SHDN_RD : plcr_pkg::S_DONE;
				else if (found) state_d = plcr_pkg::S_DONE;
				else if (cnt_q >= CW'(plcr_pkg::MaxBp)) state_d = plcr_pkg::S_DONE;
				else state_d = plcr_pkg::S_SHUP_RD;
			end
			plcr_pkg::S_DECIDE: begin
				if (func_q == plcr_pkg::FUNC_NONE) state_d = plcr_pkg::S_DONE;
				else if (func_q == plcr_pkg::FUNC_SET && pos_q > plcr_pkg::OnePos)
					state_d = plcr_pkg::S_DONE;
				else if (func_q == plcr_pkg::FUNC_SAMPLE && cnt_q == '0)
					state_d = plcr_pkg::S_DONE;
				else state_d = plcr_pkg::S_SRCH_RD;
			end
			plcr_pkg::S_SHUP_RD: state_d = plcr_pkg::S_SHUP_WR;
			plcr_pkg::S_SHUP_WR: if (j_q <= idx_q) state_d = plcr_pkg::S_DONE;
				else state_d = plcr_pkg::S_SHUP_RD;
			plcr_pkg::S_SHDN_RD: state_d = (j_q + CW'(1) >= cnt_q) ? plcr_pkg::S_DONE
				: plcr_pkg::S_SHDN_WR;
			plcr_pkg::S_SHDN_WR: state_d = plcr_pkg::S_SHDN_RD;
			plcr_pkg::S_SMP_RD: state_d = plcr_pkg::S_SMP_LD;
			plcr_pkg::S_SMP_LD: state_d = plcr_pkg::S_DIV;
			plcr_pkg::S_DIV: if (drsp.done && ch_q == 2'd3) state_d = plcr_pkg::S_DONE;
			plcr_pkg::S_DONE: state_d = plcr_pkg::S_IDLE;
			default: state_d = plcr_pkg::S_IDLE;
		endcase
	end

	// Outputs: memory access and divider start
	always_comb begin
		we = 1'b0;
		raddr = idx_q[IW-1:0];
		waddr = idx_q[IW-1:0];
		kw = pos_q;
		cw = col_q;
		dreq.start = (state_q == plcr_pkg::S_DIV) && first_q;
		dreq.num_mag = dmag;
		dreq.frac = pos_q - kp_q;
		dreq.den = kn_q - kp_q;
		case (state_q)
			plcr_pkg::S_SRCH_CHK: begin
				// recolor an existing entry in place
				if (func_q == plcr_pkg::FUNC_SET && !(idx_q < cnt_q && kr < pos_q)
					&& found && cr != col_q) we = 1'b1;
			end
			plcr_pkg::S_SHUP_RD: raddr = IW'(j_q - CW'(1));
			plcr_pkg::S_SHUP_WR: begin
				we = 1'b1;
				waddr = j_q[IW-1:0];
				if (j_q > idx_q) begin
					kw = kr;
					cw = cr;
				end
			end
			plcr_pkg::S_SHDN_RD: raddr = IW'(j_q + CW'(1));
			plcr_pkg::S_SHDN_WR: begin
				we = 1'b1;
				waddr = j_q[IW-1:0];
				kw = kr;
				cw = cr;
			end
			plcr_pkg::S_SMP_RD: begin
				if (idx_q >= cnt_q) raddr = IW'(cnt_q - CW'(1));
				else if (idx_q == '0) raddr = '0;
				else raddr = IW'(idx_q - CW'(1));
			end
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plcr_pkg::S_IDLE;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plcr_pkg::S_DONE) ovalid_q <= 1'b1;
			else if (out_acc) ovalid_q <= 1'b0;
			if (state_q == plcr_pkg::S_SHUP_WR && j_q <= idx_q) cnt_q <= cnt_q + CW'(1);
			if (state_q == plcr_pkg::S_SHDN_RD && j_q + CW'(1) >= cnt_q)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			plcr_pkg::S_IDLE: if (in_acc) begin
				func_q <= plcr_pkg::func_t'(func);
				pos_q <= position;
				col_q <= {red, green, blue, alpha};
				idx_q <= '0;
				res_q <= '0;
				st_q <= plcr_pkg::ST_SAME;
				ch_q <= '0;
			end
			plcr_pkg::S_DECIDE: begin
				if (func_q == plcr_pkg::FUNC_SET && pos_q > plcr_pkg::OnePos)
					st_q <= plcr_pkg::ST_RANGE;
				if (func_q == plcr_pkg::FUNC_SAMPLE && cnt_q == '0)
					st_q <= plcr_pkg::ST_EMPTY;
			end
			plcr_pkg::S_SRCH_CHK: begin
				if (idx_q < cnt_q && kr < pos_q) idx_q <= idx_q + CW'(1);
				else if (func_q == plcr_pkg::FUNC_REMOVE) begin
					st_q <= found ? plcr_pkg::ST_OK : plcr_pkg::ST_MISSING;
					j_q <= idx_q;
				end else if (func_q == plcr_pkg::FUNC_SET) begin
					j_q <= cnt_q;
					if (found) st_q <= (cr == col_q) ? plcr_pkg::ST_SAME : plcr_pkg::ST_OK;
					else if (cnt_q >= CW'(plcr_pkg::MaxBp)) st_q <= plcr_pkg::ST_FULL;
					else st_q <= plcr_pkg::ST_OK;
				end
				kn_q <= kr;
				cn_q <= cr;
			end
			plcr_pkg::S_SHUP_WR: j_q <= j_q - CW'(1);
			plcr_pkg::S_SHDN_WR: j_q <= j_q + CW'(1);
			plcr_pkg::S_SMP_LD: begin
				st_q <= plcr_pkg::ST_OK;
				kp_q <= kr;
				cp_q <= cr;
				if (idx_q >= cnt_q || idx_q == '0) begin
					res_q <= cr;
					cn_q <= cr;
					kn_q <= kr + 17'd1;
				end
			end
			plcr_pkg::S_DIV: if (drsp.done) begin
				res_q[5'(24 - 8 * ch_q) +: 8] <= chv;
				ch_q <= ch_q + 2'd1;
			end
			default: ;
		endcase
		// pos==kp clamp case gives frac 0, so the blend reproduces cp exactly
		if (state_q == plcr_pkg::S_SMP_LD && (idx_q >= cnt_q || idx_q == '0))
			pos_q <= kr;
	end

	// Kick a divide the cycle after the operands load and after each channel but the last ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else first_q <= (state_q == plcr_pkg::S_SMP_LD)
			|| (state_q == plcr_pkg::S_DIV && drsp.done && ch_q != 2'd3);
	end

	assign out_valid = ovalid_q;
	assign out_red = res_q[31:24];
	assign out_green = res_q[23:16];
	assign out_blue = res_q[15:8];
	assign out_alpha = res_q[7:0];
	assign status = st_q;
endmodule

// ----- rtl/plcr_ram.sv -----
// ----------------------------------------------------------------------------
// plcr_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module plcr_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/plcr_div.sv -----
// ----------------------------------------------------------------------------
// plcr_div
// Restoring divider: (mag * frac) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plcr_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plcr_pkg::div_req_t   req,
	output plcr_pkg::div_rsp_t   rsp
);
	localparam int NumW = 26;
	logic [NumW-1:0] num_q;
	logic [16:0] den_q;
	logic [17:0] rem_q;
	logic [NumW-1:0] quo_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [17:0] rem_sh;
	logic [18:0] diff;

	assign rem_sh = {rem_q[16:0], num_q[NumW-1]};
	assign diff = {1'b0, rem_sh} - {2'b00, den_q};

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(NumW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// Advance one quotient bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= NumW'(req.num_mag * req.frac);
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!diff[18]) begin
				rem_q <= diff[17:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q[7:0];
endmodule

// ----- rtl/plcr_checker.sv -----
// ----------------------------------------------------------------------------
// plcr_checker
// Port-level checks for the color ramp, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_linear_color_ramp_assert.svh"
module plcr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [2:0] status
);
	`PLCR_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")
	`PLCR_ASSERT_IMPL(a_status_range, out_valid, status <= 3'd5, "status code out of range")
	`PLCR_ASSERT_IMPL(a_busy_out, out_valid, in_stall, "input open while result waits")
	`PLCR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_red), "result dropped")
endmodule

bind piecewise_linear_color_ramp plcr_checker u_plcr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_red(out_red), .status(status));
